// ===== rtl/onewire_rom_search_engine_defines.svh =====
// Assertion macros used by the port-level checker of the ROM search engine.
`ifndef ONEWIRE_ROM_SEARCH_ENGINE_DEFINES_SVH
`define ONEWIRE_ROM_SEARCH_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define OWS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define OWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ows_pkg.sv =====
// Types and constants of the ROM search engine.
package ows_pkg;

  localparam int unsigned PosW   = 7;
  localparam int unsigned AddrW  = 64;
  localparam int unsigned FamW   = 8;
  localparam int unsigned InDW   = 16;
  localparam int unsigned OutDW  = 72;
  localparam int unsigned ReqW   = 2;
  localparam int unsigned KindW  = 3;

  typedef enum logic [ReqW-1:0] {
    REQ_RESTART = 2'd0,
    REQ_PREFIX  = 2'd1,
    REQ_BEGIN   = 2'd2,
    REQ_BITPAIR = 2'd3
  } req_e;

  typedef enum logic [KindW-1:0] {
    KIND_ACK   = 3'd0,
    KIND_PASS  = 3'd1,
    KIND_DIR   = 3'd2,
    KIND_FOUND = 3'd3,
    KIND_NONE  = 3'd4
  } kind_e;

endpackage

// ===== rtl/onewire_rom_search_engine.sv =====
// ROM search engine: an input transaction is held in the input register, its result
// in the result register. Throughput one item per cycle unless the result stalls;
// the input register feeds one decision step that updates the search state and loads
// the result register in the same cycle. Each input transaction yields exactly one
// result transaction. rst_ni is asynchronous, active low: search state cleared, bit
// position 1, both stages empty.
module onewire_rom_search_engine #(
  parameter int unsigned ROM_WIDTH = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // [7:0] family byte, [8] presence, [9] id_bit, [10] complement_bit,
  // [11] read_error, [15:12] zero
  input  logic [ows_pkg::InDW-1:0]   s_axis_tdata_i,
  // [1:0] req_type
  input  logic [ows_pkg::ReqW-1:0]   s_axis_tuser_i,
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  // [0] direction_bit, [64:1] device_address, [65] last_device, [71:66] zero
  output logic [ows_pkg::OutDW-1:0]  m_axis_tdata_o,
  // [2:0] result_kind
  output logic [ows_pkg::KindW-1:0]  m_axis_tuser_o
);

  localparam int unsigned RomW = ROM_WIDTH;
  localparam int unsigned IdxW = (RomW > 1) ? $clog2(RomW) : 1;
  localparam int unsigned PosW = ows_pkg::PosW;

  // input stage
  logic                      in_vld_q;
  ows_pkg::req_e             in_req_q;
  logic [11:0]               in_dat_q;

  // search state
  logic [RomW-1:0]           rom_q, rom_d;
  logic [PosW-1:0]           ld_q, ld_d;
  logic                      lf_q, lf_d;
  logic                      pass_q, pass_d;
  logic [PosW-1:0]           pos_q, pos_d;
  logic [PosW-1:0]           lz_q, lz_d;

  // result stage
  logic                      out_vld_q;
  ows_pkg::kind_e            kind_q, kind_d;
  logic                      dir_q, dir_d;
  logic [ows_pkg::AddrW-1:0] addr_q, addr_d;
  logic                      last_q, last_d;

  logic                      step;

  assign step            = in_vld_q && (!out_vld_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_vld_q || step;

  always_comb begin
    logic [ows_pkg::FamW-1:0] fam;
    logic                     pres, idb, cmpb, err;
    logic [PosW-1:0]          pos;
    logic [IdxW-1:0]          idx;
    logic [RomW-1:0]          rom_n;
    logic [PosW-1:0]          lz_n;

    fam  = in_dat_q[7:0];
    pres = in_dat_q[8];
    idb  = in_dat_q[9];
    cmpb = in_dat_q[10];
    err  = in_dat_q[11];

    pos = pos_q;
    if (pos_q == '0 || pos_q > PosW'(RomW)) begin
      pos = PosW'(1);
    end
    idx   = IdxW'(pos - PosW'(1));
    rom_n = rom_q;
    lz_n  = lz_q;

    rom_d  = rom_q;
    ld_d   = ld_q;
    lf_d   = lf_q;
    pass_d = pass_q;
    pos_d  = pos_q;
    lz_d   = lz_q;
    kind_d = ows_pkg::KIND_ACK;
    dir_d  = 1'b0;
    addr_d = '0;
    last_d = 1'b0;

    case (in_req_q)
      ows_pkg::REQ_RESTART: begin
        rom_d  = '0;
        ld_d   = '0;
        lf_d   = 1'b0;
        pass_d = 1'b0;
        pos_d  = PosW'(1);
        lz_d   = '0;
      end
      ows_pkg::REQ_PREFIX: begin
        rom_d  = RomW'(fam);
        ld_d   = PosW'(RomW);
        lf_d   = 1'b0;
        pass_d = 1'b0;
        pos_d  = PosW'(1);
      end
      ows_pkg::REQ_BEGIN: begin
        pos_d = PosW'(1);
        if (lf_q || !pres) begin
          ld_d   = '0;
          lf_d   = 1'b0;
          pass_d = 1'b0;
          kind_d = ows_pkg::KIND_NONE;
        end else begin
          pass_d = 1'b1;
          lz_d   = '0;
          kind_d = ows_pkg::KIND_PASS;
        end
      end
      ows_pkg::REQ_BITPAIR: begin
        if (pass_q) begin
          if (err || (idb && cmpb)) begin
            ld_d   = '0;
            lf_d   = 1'b0;
            pass_d = 1'b0;
            pos_d  = PosW'(1);
            kind_d = ows_pkg::KIND_NONE;
          end else begin
            if (idb != cmpb) begin
              dir_d = idb;
            end else begin
              // discrepancy: follow the previous path below the last branch point
              if (pos < ld_q) begin
                dir_d = rom_q[idx];
              end else begin
                dir_d = (pos == ld_q);
              end
              if (!dir_d) begin
                lz_n = pos;
              end
            end
            rom_n[idx] = dir_d;
            rom_d      = rom_n;
            lz_d       = lz_n;
            if (pos >= PosW'(RomW)) begin
              pass_d = 1'b0;
              pos_d  = PosW'(1);
              if (rom_n[7:0] == '0) begin
                ld_d   = '0;
                lf_d   = 1'b0;
                kind_d = ows_pkg::KIND_NONE;
                dir_d  = 1'b0;
              end else begin
                ld_d   = lz_n;
                lf_d   = (lz_n == '0);
                kind_d = ows_pkg::KIND_FOUND;
                addr_d = ows_pkg::AddrW'(rom_n);
                last_d = (lz_n == '0);
              end
            end else begin
              pos_d  = pos + PosW'(1);
              kind_d = ows_pkg::KIND_DIR;
            end
          end
        end
      end
      default: begin
        kind_d = ows_pkg::KIND_ACK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      rom_q     <= '0;
      ld_q      <= '0;
      lf_q      <= 1'b0;
      pass_q    <= 1'b0;
      pos_q     <= PosW'(1);
      lz_q      <= '0;
    end else begin
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (step) begin
        out_vld_q <= 1'b1;
        rom_q     <= rom_d;
        ld_q      <= ld_d;
        lf_q      <= lf_d;
        pass_q    <= pass_d;
        pos_q     <= pos_d;
        lz_q      <= lz_d;
      end else if (m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_req_q <= ows_pkg::req_e'(s_axis_tuser_i);
      in_dat_q <= s_axis_tdata_i[11:0];
    end
    if (step) begin
      kind_q <= kind_d;
      dir_q  <= dir_d;
      addr_q <= addr_d;
      last_q <= last_d;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tuser_o  = kind_q;
  assign m_axis_tdata_o  = {6'b0, last_q, addr_q, dir_q};

endmodule

// ===== rtl/ows_checker.sv =====
// Port-level checks of the ROM search engine, bound to the top level.
`include "onewire_rom_search_engine_defines.svh"

module ows_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       m_axis_tvalid_i,
  input  logic                       m_axis_tready_i,
  input  logic [ows_pkg::OutDW-1:0]  m_axis_tdata_i,
  input  logic [ows_pkg::KindW-1:0]  m_axis_tuser_i
);

  logic dir_kind;
  logic found;

  assign dir_kind = (m_axis_tuser_i == ows_pkg::KIND_DIR) ||
                    (m_axis_tuser_i == ows_pkg::KIND_FOUND);
  assign found    = (m_axis_tuser_i == ows_pkg::KIND_FOUND);

  // stalled result holds
  `OWS_ASSERT_NEXT(a_out_hold, m_axis_tvalid_i && !m_axis_tready_i, m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(m_axis_tuser_i), "result changed while stalled")
  // direction bit only in direction results
  `OWS_ASSERT_NOW(a_dir_zero, m_axis_tvalid_i && !dir_kind, m_axis_tdata_i[0] == 1'b0, "direction bit set outside direction result")
  // address and last flag only in found results
  `OWS_ASSERT_NOW(a_addr_zero, m_axis_tvalid_i && !found, m_axis_tdata_i[65:1] == '0, "address or last flag outside found result")
  // a found device never has a zero family byte
  `OWS_ASSERT_NOW(a_family, m_axis_tvalid_i && found, m_axis_tdata_i[8:1] != '0, "found device with zero family byte")

endmodule

bind onewire_rom_search_engine ows_checker u_ows_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o),
  .m_axis_tuser_i  (m_axis_tuser_o)
);

// ===== sim/testbench.sv =====
// Self-checking testbench of the ROM search engine, driving full search walks on a modeled bus.
module testbench;

  localparam int unsigned RomW        = 64;
  localparam int unsigned RandomItems = 750;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned MaxDevices  = 8;

  typedef struct packed {
    ows_pkg::kind_e kind;
    logic           dir;
    logic [63:0]    addr;
    logic           last;
  } search_reply_t;

  class rom_search_checker;
    logic [63:0]    rom_bits;
    logic [6:0]     last_disc;
    logic           last_found;
    logic           in_pass;
    logic [6:0]     bit_pos;
    logic [6:0]     zero_pos;
    ows_pkg::kind_e last_kind;
    logic           last_dir;
    search_reply_t  expected_replies[$];
    int             errors;

    function new();
      errors = 0;
      clear_search();
    endfunction

    function void clear_search();
      rom_bits   = '0;
      last_disc  = '0;
      last_found = 1'b0;
      in_pass    = 1'b0;
      bit_pos    = 7'd1;
      zero_pos   = '0;
    endfunction

    function void abort_search();
      last_disc  = '0;
      last_found = 1'b0;
      in_pass    = 1'b0;
      bit_pos    = 7'd1;
    endfunction

    // Apply one request to the search state and queue the reply it causes.
    function void note_request(ows_pkg::req_e req, logic [ows_pkg::InDW-1:0] d);
      search_reply_t r;
      logic [5:0]    idx;
      r = '{kind: ows_pkg::KIND_ACK, dir: 1'b0, addr: '0, last: 1'b0};
      case (req)
        ows_pkg::REQ_RESTART: begin
          clear_search();
        end
        ows_pkg::REQ_PREFIX: begin
          rom_bits   = {56'b0, d[7:0]};
          last_disc  = 7'(RomW);
          last_found = 1'b0;
          in_pass    = 1'b0;
          bit_pos    = 7'd1;
        end
        ows_pkg::REQ_BEGIN: begin
          if (last_found || !d[8]) begin
            abort_search();
            r.kind = ows_pkg::KIND_NONE;
          end else begin
            in_pass  = 1'b1;
            bit_pos  = 7'd1;
            zero_pos = '0;
            r.kind   = ows_pkg::KIND_PASS;
          end
        end
        default: begin
          if (in_pass) begin
            idx = 6'(bit_pos - 7'd1);
            if (d[11] || (d[9] && d[10])) begin
              abort_search();
              r.kind = ows_pkg::KIND_NONE;
            end else begin
              if (d[9] != d[10]) begin
                r.dir = d[9];
              end else begin
                if (bit_pos < last_disc) r.dir = rom_bits[idx];
                else r.dir = (bit_pos == last_disc);
                if (!r.dir) zero_pos = bit_pos;
              end
              rom_bits[idx] = r.dir;
              if (bit_pos >= 7'(RomW)) begin
                in_pass    = 1'b0;
                bit_pos    = 7'd1;
                last_disc  = zero_pos;
                last_found = (zero_pos == '0);
                // all-zero family byte counts as no device
                if (rom_bits[7:0] == 8'h00) begin
                  abort_search();
                  r.kind = ows_pkg::KIND_NONE;
                  r.dir  = 1'b0;
                end else begin
                  r.kind = ows_pkg::KIND_FOUND;
                  r.addr = rom_bits;
                  r.last = last_found;
                end
              end else begin
                bit_pos = bit_pos + 7'd1;
                r.kind  = ows_pkg::KIND_DIR;
              end
            end
          end
        end
      endcase
      last_kind = r.kind;
      last_dir  = r.dir;
      expected_replies.push_back(r);
    endfunction

    function void check_result(logic [ows_pkg::KindW-1:0] kind,
                               logic [ows_pkg::OutDW-1:0] d);
      search_reply_t e;
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d data %h",
                 $time, kind, d);
        errors++;
        return;
      end
      e = expected_replies.pop_front();
      if (kind !== e.kind) begin
        $display("%0t: result_kind expected %0d actual %0d", $time, e.kind, kind);
        errors++;
      end
      if (d[0] !== e.dir) begin
        $display("%0t: direction_bit expected %0d actual %0d", $time, e.dir, d[0]);
        errors++;
      end
      if (d[64:1] !== e.addr) begin
        $display("%0t: device_address expected %h actual %h", $time, e.addr, d[64:1]);
        errors++;
      end
      if (d[65] !== e.last) begin
        $display("%0t: last_device expected %0d actual %0d", $time, e.last, d[65]);
        errors++;
      end
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction
  endclass

  logic                          clk_i;
  logic                          rst_ni;
  logic                          s_axis_tvalid_i;
  logic                          s_axis_tready_o;
  logic [ows_pkg::InDW-1:0]      s_axis_tdata_i;
  logic [ows_pkg::ReqW-1:0]      s_axis_tuser_i;
  logic                          m_axis_tvalid_o;
  logic                          m_axis_tready_i;
  logic [ows_pkg::OutDW-1:0]     m_axis_tdata_o;
  logic [ows_pkg::KindW-1:0]     m_axis_tuser_o;

  rom_search_checker sb;
  int unsigned       send_idle_pct;
  int unsigned       recv_stall_pct;
  int unsigned       items_sent;
  int unsigned       item_goal;
  int unsigned       cycles;

  // bus model: devices on the wire and which of them still follow the walk
  logic [63:0]       dev_id [MaxDevices];
  bit                alive  [MaxDevices];
  int                ndev;

  onewire_rom_search_engine #(
    .ROM_WIDTH(RomW)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic logic [ows_pkg::InDW-1:0] pack_req(logic [7:0] fam, logic pres,
                                                        logic idb, logic cmpb, logic err);
    return {4'b0, err, cmpb, idb, pres, fam};
  endfunction

  function automatic logic [ows_pkg::InDW-1:0] rand_req_data();
    return pack_req(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom));
  endfunction

  // Called at a rising edge; returns at the edge where the transaction is taken.
  task automatic send(ows_pkg::req_e req, logic [ows_pkg::InDW-1:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= d;
    s_axis_tuser_i  <= req;
    forever begin
      @(negedge clk_i);
      if (s_axis_tready_o) break;
    end
    @(posedge clk_i);
    sb.note_request(req, d);
    items_sent++;
  endtask

  // Wired-AND read of the id bit and its complement among the devices still in the walk.
  task automatic send_bus_bitpair(int pos);
    logic idb;
    logic cmpb;
    idb  = 1'b1;
    cmpb = 1'b1;
    for (int k = 0; k < ndev; k++) begin
      if (alive[k]) begin
        idb  = idb & dev_id[k][pos-1];
        cmpb = cmpb & ~dev_id[k][pos-1];
      end
    end
    send(ows_pkg::REQ_BITPAIR, pack_req(8'($urandom), 1'($urandom), idb, cmpb, 1'b0));
    for (int k = 0; k < ndev; k++) begin
      if (dev_id[k][pos-1] != sb.last_dir) alive[k] = 1'b0;
    end
  endtask

  task automatic send_disruption();
    case ($urandom_range(4))
      0: send(ows_pkg::REQ_BITPAIR, pack_req(8'($urandom), 1'($urandom), 1'($urandom),
                                             1'($urandom), 1'b1));
      1: send(ows_pkg::REQ_BITPAIR, pack_req(8'($urandom), 1'($urandom), 1'b1, 1'b1, 1'b0));
      2: send(ows_pkg::REQ_RESTART, rand_req_data());
      3: send(ows_pkg::REQ_PREFIX, rand_req_data());
      default: send(ows_pkg::REQ_BEGIN, rand_req_data());
    endcase
  endtask

  task automatic run_search(bit zero_family);
    int  src;
    int  b;
    bit  stop;
    ndev = zero_family ? 1 : (($urandom_range(15) == 0) ? 0 : $urandom_range(1, 4));
    for (int k = 0; k < ndev; k++) begin
      if (k > 0 && $urandom_range(1) == 1) begin
        // same family, differs deeper in the address: forces discrepancies
        src = $urandom_range(k - 1);
        dev_id[k] = dev_id[src];
        dev_id[k][$urandom_range(63, 8)] ^= 1'b1;
      end else begin
        dev_id[k] = {$urandom, $urandom};
        dev_id[k][7:0] = ($urandom_range(19) == 0) ? 8'h00 : 8'($urandom_range(255, 1));
      end
    end
    if (zero_family) dev_id[0][7:0] = 8'h00;
    if (ndev > 0 && $urandom_range(3) == 0) begin
      send(ows_pkg::REQ_PREFIX, pack_req(dev_id[0][7:0], 1'($urandom), 1'($urandom),
                                         1'($urandom), 1'($urandom)));
    end else begin
      send(ows_pkg::REQ_RESTART, rand_req_data());
    end
    stop = 1'b0;
    for (int p = 0; p < ndev + 3 && !stop && items_sent < item_goal; p++) begin
      for (int k = 0; k < MaxDevices; k++) alive[k] = 1'b1;
      send(ows_pkg::REQ_BEGIN, pack_req(8'($urandom), (ndev > 0), 1'($urandom),
                                        1'($urandom), 1'($urandom)));
      if (sb.last_kind != ows_pkg::KIND_PASS) stop = 1'b1;
      b = 1;
      while (b <= RomW && !stop && items_sent < item_goal) begin
        if ($urandom_range(199) == 0) begin
          send_disruption();
          stop = 1'b1;
        end else begin
          send_bus_bitpair(b);
          if (sb.last_kind == ows_pkg::KIND_NONE) stop = 1'b1;
        end
        b++;
      end
    end
    repeat ($urandom_range(3)) begin
      send(ows_pkg::req_e'(2'($urandom_range(3))), rand_req_data());
    end
  endtask

  task automatic run_directed();
    send(ows_pkg::REQ_BITPAIR, pack_req(8'h00, 1'b0, 1'b1, 1'b0, 1'b0));   // no pass open
    send(ows_pkg::REQ_BEGIN,   pack_req(8'h00, 1'b0, 1'b0, 1'b0, 1'b0));   // no presence
    send(ows_pkg::REQ_PREFIX,  pack_req(8'hFF, 1'b1, 1'b1, 1'b1, 1'b1));
    send(ows_pkg::REQ_BEGIN,   pack_req(8'hFF, 1'b1, 1'b0, 1'b0, 1'b0));
    send(ows_pkg::REQ_BITPAIR, pack_req(8'h00, 1'b0, 1'b1, 1'b0, 1'b0));
    send(ows_pkg::REQ_BITPAIR, pack_req(8'h00, 1'b0, 1'b0, 1'b1, 1'b0));
    send(ows_pkg::REQ_BITPAIR, pack_req(8'h00, 1'b0, 1'b0, 1'b0, 1'b0));   // discrepancy
    send(ows_pkg::REQ_BEGIN,   pack_req(8'h00, 1'b1, 1'b0, 1'b0, 1'b0));   // restart the pass
    send(ows_pkg::REQ_BITPAIR, pack_req(8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
    send(ows_pkg::REQ_BITPAIR, pack_req(8'hFF, 1'b1, 1'b0, 1'b1, 1'b1));   // read error
    send(ows_pkg::REQ_BITPAIR, pack_req(8'h00, 1'b0, 1'b0, 1'b1, 1'b0));   // pass is closed
    send(ows_pkg::REQ_BEGIN,   pack_req(8'h00, 1'b1, 1'b1, 1'b1, 1'b1));
    send(ows_pkg::REQ_BITPAIR, pack_req(8'h00, 1'b0, 1'b1, 1'b1, 1'b0));   // both bits high
    send(ows_pkg::REQ_RESTART, pack_req(8'hFF, 1'b1, 1'b1, 1'b1, 1'b1));
    send(ows_pkg::REQ_PREFIX,  pack_req(8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
    send(ows_pkg::REQ_BEGIN,   pack_req(8'h00, 1'b1, 1'b0, 1'b0, 1'b0));
    send(ows_pkg::REQ_BITPAIR, pack_req(8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
    send(ows_pkg::REQ_RESTART, pack_req(8'h00, 1'b0, 1'b0, 1'b0, 1'b0));
  endtask

  initial begin
    sb = new();
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    items_sent      = 0;
    item_goal       = 0;
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= ows_pkg::REQ_RESTART;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      item_goal = 18 + (ph + 1) * RandomItems / 4;
      while (items_sent < item_goal) begin
        run_search(ph == 0 && items_sent < 20);
      end
      // hold off the sender until every reply is back
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while (sb.pending() > 0);
    end

    repeat (DrainCycles) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("[onewire_rom_search_engine] OK");
    end else begin
      $display("[onewire_rom_search_engine] ERROR");
    end
    $finish;
  end

  initial begin
    m_axis_tready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
      @(negedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
        sb.check_result(m_axis_tuser_o, m_axis_tdata_o);
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CycleLimit) begin
        $display("%0t: timeout", $time);
        $display("[onewire_rom_search_engine] ERROR");
        $finish;
      end
    end
  end

endmodule

// ===== onewire_rom_search_engine.f =====
+incdir+rtl
rtl/ows_pkg.sv
rtl/onewire_rom_search_engine.sv
rtl/ows_checker.sv
sim/testbench.sv
